FILE: design/idhc_pkg.sv
package idhc_pkg;

    // fixed field widths
    localparam int AXIS_PORT_W = 16;
    localparam int TIME_W      = 32;
    localparam int TOTAL_W     = 16;
    localparam int THR_W       = 34;
    localparam int MS_W        = 16;
    localparam int CFG_DATA_W  = 34;
    localparam int CFG_IDX_W   = 2;

    // parameter defaults
    localparam int AXIS_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 34'd150994944;
    localparam logic [MS_W-1:0]  HOLD_RST      = 16'd5000;
    localparam logic [MS_W-1:0]  DEBOUNCE_RST  = 16'd300;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_HOLD      = 2'd1,
        CFG_DEBOUNCE  = 2'd2,
        CFG_PRESENT   = 2'd3
    } cfg_idx_t;

    // request types
    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_CLEAR  = 1'b1
    } req_t;

endpackage

FILE: design/impact_detect_hold_count.sv
// channel  | handshake                 | payload
// ---------+---------------------------+--------------------------------------------
// in       | in_valid / in_ready       | req_type, accel_x/y/z, now_ms
// out      | out_valid / out_ready     | impact_active, impact_raw, impact_total
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// one request per cycle sustained while out_ready keeps up; a request is registered in
// the input stage, then evaluated and its result registered in the result register
// the squarer/compare path between input and result register sets the clock
// rst_n clears control state and loads register defaults; prev sample is unprimed
// a stalled result register holds the input stage; in_ready drops only when both are full
module impact_detect_hold_count #(
    parameter int AXIS_WIDTH  = idhc_pkg::AXIS_WIDTH_DEF,
    parameter int COUNT_WIDTH = idhc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 req_type,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_x,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_y,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_z,
    input  logic [idhc_pkg::TIME_W-1:0]          now_ms,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 impact_active,
    output logic                                 impact_raw,
    output logic [idhc_pkg::TOTAL_W-1:0]         impact_total,
    input  logic                                 cfg_we,
    input  logic [idhc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [idhc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import idhc_pkg::*;

    // configuration registers
    logic [THR_W-1:0] threshold_reg;
    logic [MS_W-1:0]  hold_time_reg;
    logic [MS_W-1:0]  debounce_reg;
    logic             present_reg;

    // input stage
    logic                         s1_valid_reg;
    logic                         s1_req_reg;
    logic signed [AXIS_WIDTH-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [TIME_W-1:0]            s1_now_reg;

    // detector state
    logic signed [AXIS_WIDTH-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [AXIS_WIDTH-1:0] prev_x_next, prev_y_next, prev_z_next;
    logic                         primed_reg, primed_next;
    logic                         last_raw_reg, last_raw_next;
    logic                         active_reg, active_next;
    logic [TIME_W-1:0]            hold_start_reg, hold_start_next;
    logic [TIME_W-1:0]            last_count_reg, last_count_next;
    logic [COUNT_WIDTH-1:0]       counter_reg, counter_next;
    logic                         raw_next;

    // result register
    logic               out_valid_reg;
    logic               out_active_reg;
    logic               out_raw_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic        fire;
    logic        mag_raw;
    logic [TIME_W-1:0] since_count, since_hold;

    assign fire     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            hold_time_reg <= HOLD_RST;
            debounce_reg  <= DEBOUNCE_RST;
            present_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                CFG_HOLD:      hold_time_reg <= cfg_data[MS_W-1:0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data[MS_W-1:0];
                CFG_PRESENT:   present_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg <= req_type;
            s1_x_reg   <= accel_x[AXIS_WIDTH-1:0];
            s1_y_reg   <= accel_y[AXIS_WIDTH-1:0];
            s1_z_reg   <= accel_z[AXIS_WIDTH-1:0];
            s1_now_reg <= now_ms;
        end
    end

    // squared change magnitude against threshold
    idhc_mag #(
        .AXIS_WIDTH (AXIS_WIDTH)
    ) u_mag (
        .cur_x     (s1_x_reg),
        .cur_y     (s1_y_reg),
        .cur_z     (s1_z_reg),
        .prev_x    (prev_x_reg),
        .prev_y    (prev_y_reg),
        .prev_z    (prev_z_reg),
        .threshold (threshold_reg),
        .raw       (mag_raw)
    );

    // wrap-safe elapsed times
    assign since_count = s1_now_reg - last_count_reg;
    assign since_hold  = s1_now_reg - hold_start_reg;

    // next state for the request in the input stage
    always_comb
    begin
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_z_next     = prev_z_reg;
        primed_next     = primed_reg;
        last_raw_next   = last_raw_reg;
        active_next     = active_reg;
        hold_start_next = hold_start_reg;
        last_count_next = last_count_reg;
        counter_next    = counter_reg;
        raw_next        = 1'b0;

        if (req_t'(s1_req_reg) == REQ_CLEAR)
        begin
            counter_next = '0;
        end
        else if (present_reg)
        begin
            prev_x_next = s1_x_reg;
            prev_y_next = s1_y_reg;
            prev_z_next = s1_z_reg;
            primed_next = 1'b1;
            if (primed_reg)
            begin
                raw_next      = mag_raw;
                last_raw_next = mag_raw;
                if (mag_raw)
                begin
                    // restart hold window; elapsed is zero so no expiry
                    hold_start_next = s1_now_reg;
                    active_next     = 1'b1;
                    if (!last_raw_reg && since_count > TIME_W'(debounce_reg))
                    begin
                        if (counter_reg != '1)
                        begin
                            counter_next = counter_reg + 1'b1;
                        end
                        last_count_next = s1_now_reg;
                    end
                end
                else if (active_reg && since_hold > TIME_W'(hold_time_reg))
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_z_reg     <= '0;
            primed_reg     <= 1'b0;
            last_raw_reg   <= 1'b0;
            active_reg     <= 1'b0;
            hold_start_reg <= '0;
            last_count_reg <= '0;
            counter_reg    <= '0;
        end
        else if (fire)
        begin
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            prev_z_reg     <= prev_z_next;
            primed_reg     <= primed_next;
            last_raw_reg   <= last_raw_next;
            active_reg     <= active_next;
            hold_start_reg <= hold_start_next;
            last_count_reg <= last_count_next;
            counter_reg    <= counter_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_active_reg <= active_next;
            out_raw_reg    <= raw_next;
            out_total_reg  <= TOTAL_W'(counter_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign impact_active = out_active_reg;
    assign impact_raw    = out_raw_reg;
    assign impact_total  = out_total_reg;

endmodule

FILE: design/idhc_mag.sv
module idhc_mag #(
    parameter int AXIS_WIDTH = idhc_pkg::AXIS_WIDTH_DEF
) (
    input  logic signed [AXIS_WIDTH-1:0]   cur_x,
    input  logic signed [AXIS_WIDTH-1:0]   cur_y,
    input  logic signed [AXIS_WIDTH-1:0]   cur_z,
    input  logic signed [AXIS_WIDTH-1:0]   prev_x,
    input  logic signed [AXIS_WIDTH-1:0]   prev_y,
    input  logic signed [AXIS_WIDTH-1:0]   prev_z,
    input  logic [idhc_pkg::THR_W-1:0]     threshold,
    output logic                           raw
);
    import idhc_pkg::*;

    localparam int DIFF_W = AXIS_WIDTH + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic signed [SQ_W-1:0]   sq_x, sq_y, sq_z;
    logic [SUM_W-1:0]         mag;

    // change vector per axis
    assign dx = DIFF_W'(cur_x) - DIFF_W'(prev_x);
    assign dy = DIFF_W'(cur_y) - DIFF_W'(prev_y);
    assign dz = DIFF_W'(cur_z) - DIFF_W'(prev_z);

    // three independent squarers
    assign sq_x = SQ_W'(dx) * SQ_W'(dx);
    assign sq_y = SQ_W'(dy) * SQ_W'(dy);
    assign sq_z = SQ_W'(dz) * SQ_W'(dz);

    // squared magnitude and threshold compare
    assign mag = SUM_W'($unsigned(sq_x)) + SUM_W'($unsigned(sq_y))
               + SUM_W'($unsigned(sq_z));
    assign raw = CMP_W'(mag) >= CMP_W'(threshold);

endmodule

FILE: dv/impact_detect_hold_count_checker.sv
module impact_detect_hold_count_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    req_type,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_x,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_y,
    input  logic signed [idhc_pkg::AXIS_PORT_W-1:0] accel_z,
    input  logic [idhc_pkg::TIME_W-1:0]             now_ms,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic                                    impact_active,
    input  logic                                    impact_raw,
    input  logic [idhc_pkg::TOTAL_W-1:0]            impact_total,
    input  logic                                    cfg_we,
    input  logic [idhc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [idhc_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                      fail_count,
    output int                                      pending
);
    import idhc_pkg::*;

    localparam int MAX_PRINTED = 100;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic               active;
        logic               raw;
        logic [TOTAL_W-1:0] total;
    } impact_flags_t;

    // register copies
    logic [THR_W-1:0] thr_q;
    logic [MS_W-1:0]  hold_q;
    logic [MS_W-1:0]  debounce_q;
    logic             present_q;

    // detector state copies
    logic signed [AXIS_PORT_W-1:0] prev_x_q;
    logic signed [AXIS_PORT_W-1:0] prev_y_q;
    logic signed [AXIS_PORT_W-1:0] prev_z_q;
    logic                          primed_q;
    logic                          last_raw_q;
    logic                          active_q;
    logic [TIME_W-1:0]             hold_start_q;
    logic [TIME_W-1:0]             last_count_q;
    logic [COUNT_WIDTH_DEF-1:0]    counter_q;

    impact_flags_t expected_flags[$];
    int            mismatches = 0;
    int            results_seen = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR at %0t, result %0d: %s", $time, results_seen, msg);
    endtask

    // advance the detector by one request and give the flags it shows
    task automatic predict_impact(
        input  logic                          rq,
        input  logic signed [AXIS_PORT_W-1:0] ax,
        input  logic signed [AXIS_PORT_W-1:0] ay,
        input  logic signed [AXIS_PORT_W-1:0] az,
        input  logic [TIME_W-1:0]             t,
        output impact_flags_t                 res
    );
        longint            dx;
        longint            dy;
        longint            dz;
        logic [THR_W-1:0]  mag;
        logic [TIME_W-1:0] since_count;
        logic [TIME_W-1:0] since_hold;
        logic              hit;
        hit = 1'b0;
        if (req_t'(rq) == REQ_CLEAR)
        begin
            counter_q = '0;
        end
        else if (present_q && !primed_q)
        begin
            // first sample only loads the previous values
            prev_x_q = ax;
            prev_y_q = ay;
            prev_z_q = az;
            primed_q = 1'b1;
        end
        else if (present_q)
        begin
            dx = longint'(ax) - longint'(prev_x_q);
            dy = longint'(ay) - longint'(prev_y_q);
            dz = longint'(az) - longint'(prev_z_q);
            mag = THR_W'(dx * dx + dy * dy + dz * dz);
            prev_x_q = ax;
            prev_y_q = ay;
            prev_z_q = az;
            hit = (mag >= thr_q);
            if (hit)
            begin
                hold_start_q = t;
                active_q = 1'b1;
            end
            // debounced count on the rising edge of the raw flag
            since_count = t - last_count_q;
            if (hit && !last_raw_q && since_count > TIME_W'(debounce_q))
            begin
                if (counter_q != COUNT_FULL)
                    counter_q = counter_q + 1'b1;
                last_count_q = t;
            end
            since_hold = t - hold_start_q;
            if (active_q && since_hold > TIME_W'(hold_q))
                active_q = 1'b0;
            last_raw_q = hit;
        end
        res.active = active_q;
        res.raw = hit;
        res.total = TOTAL_W'(counter_q);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        impact_flags_t want;
        if (!rst_n)
        begin
            thr_q = THRESHOLD_RST;
            hold_q = HOLD_RST;
            debounce_q = DEBOUNCE_RST;
            present_q = 1'b1;
            prev_x_q = '0;
            prev_y_q = '0;
            prev_z_q = '0;
            primed_q = 1'b0;
            last_raw_q = 1'b0;
            active_q = 1'b0;
            hold_start_q = '0;
            last_count_q = '0;
            counter_q = '0;
            expected_flags.delete();
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_THRESHOLD: thr_q = cfg_data[THR_W-1:0];
                    CFG_HOLD:      hold_q = cfg_data[MS_W-1:0];
                    CFG_DEBOUNCE:  debounce_q = cfg_data[MS_W-1:0];
                    CFG_PRESENT:   present_q = cfg_data[0];
                    default:       ;
                endcase
            end

            // compare an accepted result against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_flags.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (impact_active !== want.active)
                        report_mismatch($sformatf("impact_active exp %0b got %0b",
                                                  want.active, impact_active));
                    if (impact_raw !== want.raw)
                        report_mismatch($sformatf("impact_raw exp %0b got %0b",
                                                  want.raw, impact_raw));
                    if (impact_total !== want.total)
                        report_mismatch($sformatf("impact_total exp %0d got %0d",
                                                  want.total, impact_total));
                end
                results_seen++;
            end

            // predict for an accepted request
            if (in_valid && in_ready)
            begin
                predict_impact(req_type, accel_x, accel_y, accel_z, now_ms, want);
                expected_flags.push_back(want);
            end

            pending <= expected_flags.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: dv/impact_detect_hold_count_tb.sv
module impact_detect_hold_count_tb;
    import idhc_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASE_ITEMS     = 225;
    localparam int SAT_ROUNDS      = 25;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [THR_W-1:0] THRESHOLD_MAX = 34'd12884508675;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          req_type = 1'b0;
    logic signed [AXIS_PORT_W-1:0] accel_x = '0;
    logic signed [AXIS_PORT_W-1:0] accel_y = '0;
    logic signed [AXIS_PORT_W-1:0] accel_z = '0;
    logic [TIME_W-1:0]             now_ms = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          impact_active;
    logic                          impact_raw;
    logic [TOTAL_W-1:0]            impact_total;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   burst_left = 0;
    bit   no_gaps = 1'b0;
    bit   fast_rx = 1'b0;
    logic hold_off_req = 1'b0;

    impact_detect_hold_count uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .impact_active (impact_active),
        .impact_raw    (impact_raw),
        .impact_total  (impact_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    impact_detect_hold_count_checker impact_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .impact_active (impact_active),
        .impact_raw    (impact_raw),
        .impact_total  (impact_total),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result-side stall pattern, with one long hold-off on demand
    int rx_mode = 0;
    int rx_phase = 0;
    int stall_left = 0;
    bit hold_off_done = 1'b0;

    always @(posedge clk)
    begin
        if (hold_off_req && !hold_off_done)
        begin
            hold_off_done = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
        end
        if (rx_phase == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_phase = $urandom_range(16, 96);
        end
        rx_phase--;
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (fast_rx)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_phase % 4 != 0);
            endcase
        end
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom());
    endfunction

    // small signed wobble around a resting value
    function automatic logic [15:0] jitter();
        return 16'($urandom_range(0, 511)) - 16'd256;
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return MS_W'($urandom_range(0, 64));
            3:       return MS_W'($urandom_range(0, 600));
            default: return MS_W'($urandom());
        endcase
    endfunction

    // offer one request, in bursts with random gaps, and wait for acceptance
    task automatic send_request(
        input req_t        rq,
        input logic [15:0] x,
        input logic [15:0] y,
        input logic [15:0] z,
        input logic [31:0] t
    );
        int gap;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rq;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        now_ms <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers on consecutive cycles
    task automatic apply_settings(
        input logic [THR_W-1:0] thr,
        input logic [MS_W-1:0]  hold,
        input logic [MS_W-1:0]  deb,
        input logic             present
    );
        cfg_we <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data <= CFG_DATA_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_HOLD;
        cfg_data <= CFG_DATA_W'(hold);
        @(posedge clk);
        cfg_index <= CFG_DEBOUNCE;
        cfg_data <= CFG_DATA_W'(deb);
        @(posedge clk);
        cfg_index <= CFG_PRESENT;
        cfg_data <= CFG_DATA_W'(present);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random settings, then mostly quiet samples with jolts, plus noise and clears
    task automatic run_phase(input int n, input bit with_hold_off);
        logic [15:0]      bx;
        logic [15:0]      by;
        logic [15:0]      bz;
        logic [31:0]      t;
        logic [THR_W-1:0] thr;
        int               r;
        bx = rand16();
        by = rand16();
        bz = rand16();
        t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom();
        case ($urandom_range(0, 5))
            0: thr = '0;
            1: thr = THRESHOLD_MAX;
            2: thr = THRESHOLD_RST;
            3: thr = THR_W'($urandom_range(0, 1 << 20));
            4: thr = THR_W'($urandom_range(1 << 24, 32'h7FFF_FFFF));
            default:
            begin
                thr = {2'($urandom_range(0, 2)), 32'($urandom())};
                if (thr > THRESHOLD_MAX)
                    thr = THRESHOLD_MAX;
            end
        endcase
        drain_results();
        apply_settings(thr, pick_ms(), pick_ms(), ($urandom_range(0, 5) != 0));
        for (int i = 0; i < n; i++)
        begin
            // long result stall while requests keep coming back to back
            if (with_hold_off && i == 100)
            begin
                hold_off_req <= 1'b1;
                no_gaps = 1'b1;
            end
            if (with_hold_off && i == 160)
                no_gaps = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                send_request(REQ_CLEAR, rand16(), rand16(), rand16(), $urandom());
            end
            else if (r < 12)
            begin
                send_request(REQ_SAMPLE, rand16(), rand16(), rand16(), $urandom());
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    t = t + $urandom_range(0, 70000);
                else
                    t = t + $urandom_range(0, 40);
                if ($urandom_range(0, 4) == 0)
                    send_request(REQ_SAMPLE, rand16(), rand16(), rand16(), t);
                else
                    send_request(REQ_SAMPLE, bx + jitter(), by + jitter(), bz + jitter(), t);
            end
        end
    endtask

    // alternate two resting values at full rate, every edge counted
    task automatic run_saturation();
        logic [31:0] t;
        t = 32'hFFFF_FF00;
        drain_results();
        no_gaps = 1'b1;
        fast_rx = 1'b1;
        apply_settings(34'd1, '0, '0, 1'b1);
        send_request(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, t);
        t++;
        send_request(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, t);
        for (int k = 0; k < SAT_ROUNDS; k++)
        begin
            t++;
            send_request(REQ_SAMPLE, 16'd1000, 16'd0, 16'd0, t);
            t++;
            send_request(REQ_SAMPLE, 16'd1000, 16'd0, 16'd0, t);
            t++;
            send_request(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, t);
            t++;
            send_request(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, t);
        end
        drain_results();
        fast_rx = 1'b0;
        no_gaps = 1'b0;
    endtask

    // stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: priming, early edge, counted edge, hold expiry, clear
        send_request(REQ_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 32'd100);
        send_request(REQ_CLEAR, rand16(), rand16(), rand16(), $urandom());
        send_request(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 32'd200);
        send_request(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000, 32'd400);
        send_request(REQ_SAMPLE, 16'h7FFF, 16'h8000, 16'h8000, 32'd1000);
        send_request(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF, 32'd1100);
        send_request(REQ_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF, 32'd7000);
        send_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // top threshold hit exactly, zero hold and debounce, time wrap
        drain_results();
        apply_settings(THRESHOLD_MAX, '0, '0, 1'b1);
        send_request(REQ_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFF0);
        send_request(REQ_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF);
        send_request(REQ_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0005);
        send_request(REQ_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0006);

        // zero threshold, longest hold and debounce across the wrap
        drain_results();
        apply_settings('0, '1, '1, 1'b1);
        send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd10);
        send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd20);

        // sensor absent: samples ignored, clear still works
        drain_results();
        apply_settings(THRESHOLD_RST, HOLD_RST, DEBOUNCE_RST, 1'b0);
        send_request(REQ_SAMPLE, 16'd12345, 16'hFFFF, 16'h8000, 32'd30);
        send_request(REQ_CLEAR, rand16(), rand16(), rand16(), $urandom());
        send_request(REQ_SAMPLE, rand16(), rand16(), rand16(), $urandom());

        // back to reset values, hold runs out after a long gap
        drain_results();
        apply_settings(THRESHOLD_RST, HOLD_RST, DEBOUNCE_RST, 1'b1);
        send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 32'd40);
        send_request(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000);

        // random part
        run_phase(PHASE_ITEMS, 1'b0);
        run_phase(PHASE_ITEMS, 1'b1);
        run_phase(PHASE_ITEMS, 1'b0);
        run_saturation();
        run_phase(PHASE_ITEMS, 1'b0);
        run_phase(PHASE_ITEMS, 1'b0);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
